FILE: hw/rtl/embroidery_stitch_stream_decoder_defines.svh
`ifndef EMBROIDERY_STITCH_STREAM_DECODER_DEFINES_SVH
`define EMBROIDERY_STITCH_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

  // Header length in bytes, 1 to 511.
  localparam int HEADER_BYTES = 256;
  localparam int HDR_CNT_W    = 9;

  localparam logic [7:0] ESC_MARK  = 8'h80;
  localparam logic [7:0] CODE_STOP = 8'h02;
  localparam logic [7:0] CODE_TRIM = 8'h03;
  localparam logic [7:0] CODE_END  = 8'h7E;

  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_TRIM   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // One parsed record: a plain byte pair (bytes in x[7:0], y[7:0]) or an
  // escape with its code and 16-bit values.
  typedef struct packed {
    logic        is_escape;
    logic [7:0]  code;
    logic [15:0] x;
    logic [15:0] y;
  } esd_rec_t;

endpackage

FILE: hw/rtl/embroidery_stitch_stream_decoder.sv
`timescale 1ns / 1ps
// Stitch stream decoder.
// Input channel: one file byte per word on in_byte, taken when push is high
// and full is low. The first HEADER_BYTES bytes are skipped, then byte pairs
// and seven-byte escape records are decoded into stitches.
// Result channel: step_x, step_y, stitch_kind are valid while empty is low;
// the word is taken when pop is high. Plain pairs give kind 0 with the bytes
// sign-extended; escapes give stop, trim, end (zero displacement) or normal.
// After the end record every byte is taken and dropped until reset.
// Throughput: one byte per cycle, sustained while full is low. The parser
// writes a four-entry queue at the edge that takes the last byte of a record;
// the output register loads from the queue when it is free or being taken.
// When the receiver stalls, results collect in the queue; once the queue is
// full, full rises and input stalls, including header and mid-record bytes.
// Reset (rst, synchronous) returns the parser to header skip and empties the
// queue and the output register.
module embroidery_stitch_stream_decoder import esd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] step_x,
  output logic signed [15:0] step_y,
  output logic [1:0]         stitch_kind
);

  logic     accept;
  logic     rec_valid;
  esd_rec_t rec;
  esd_rec_t q_data;
  logic     q_empty;
  logic     q_pop;

  assign accept = push && !full;

  esd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  esd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_valid),
    .wr_data (rec),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .q_empty (q_empty)
  );

  esd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .step_x      (step_x),
    .step_y      (step_y),
    .stitch_kind (stitch_kind)
  );

endmodule

FILE: hw/rtl/esd_front.sv
`timescale 1ns / 1ps
`include "embroidery_stitch_stream_decoder_defines.svh"

module esd_front import esd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic [7:0] in_byte,
  output logic     rec_valid,
  output esd_rec_t rec
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_SECOND = 3'd2;
  localparam logic [2:0] PH_CODE   = 3'd3;
  localparam logic [2:0] PH_XLO    = 3'd4;
  localparam logic [2:0] PH_XHI    = 3'd5;
  localparam logic [2:0] PH_YLO    = 3'd6;
  localparam logic [2:0] PH_YHI    = 3'd7;

  logic [2:0]           phase, phase_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [7:0]           first_byte, first_byte_next;
  logic [7:0]           escape_code, escape_code_next;
  logic [7:0]           low_byte, low_byte_next;
  logic [15:0]          held_x, held_x_next;
  logic                 finished, finished_next;
  logic                 take;

  assign take = accept && !finished;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    first_byte_next   = first_byte;
    escape_code_next  = escape_code;
    low_byte_next     = low_byte;
    held_x_next       = held_x;
    finished_next     = finished;
    rec_valid         = 1'b0;
    rec.is_escape     = 1'b0;
    rec.code          = escape_code;
    rec.x             = {8'h00, first_byte};
    rec.y             = {8'h00, in_byte};
    if (take) begin
      unique case (phase)
        PH_HEADER: begin
          header_count_next = header_count + 1'b1;
          if (header_count_next >= HDR_CNT_W'(HEADER_BYTES)) begin
            phase_next = PH_FIRST;
          end
        end
        PH_FIRST: begin
          first_byte_next = in_byte;
          phase_next      = PH_SECOND;
        end
        PH_SECOND: begin
          // drop the pad byte of an escape
          if (first_byte == ESC_MARK) begin
            phase_next = PH_CODE;
          end else begin
            phase_next = PH_FIRST;
            rec_valid  = 1'b1;
          end
        end
        PH_CODE: begin
          escape_code_next = in_byte;
          phase_next       = PH_XLO;
        end
        PH_XLO: begin
          low_byte_next = in_byte;
          phase_next    = PH_XHI;
        end
        PH_XHI: begin
          held_x_next = {in_byte, low_byte};
          phase_next  = PH_YLO;
        end
        PH_YLO: begin
          low_byte_next = in_byte;
          phase_next    = PH_YHI;
        end
        PH_YHI: begin
          phase_next    = PH_FIRST;
          rec_valid     = 1'b1;
          rec.is_escape = 1'b1;
          rec.x         = held_x;
          rec.y         = {in_byte, low_byte};
          if (escape_code == CODE_END) begin
            finished_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      first_byte   <= '0;
      escape_code  <= '0;
      low_byte     <= '0;
      held_x       <= '0;
      finished     <= 1'b0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      first_byte   <= first_byte_next;
      escape_code  <= escape_code_next;
      low_byte     <= low_byte_next;
      held_x       <= held_x_next;
      finished     <= finished_next;
    end
  end

  `ESD_ASSERT_NEXT(a_finished_sticky, finished, finished, "end of stream flag cleared")
  `ESD_ASSERT_NOW(a_no_rec_in_header, phase == PH_HEADER, !rec_valid, "record during header")

endmodule

FILE: hw/rtl/esd_queue.sv
`timescale 1ns / 1ps
`include "embroidery_stitch_stream_decoder_defines.svh"

module esd_queue import esd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  esd_rec_t wr_data,
  input  logic     rd_en,
  output esd_rec_t rd_data,
  output logic     full,
  output logic     q_empty
);

  esd_rec_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `ESD_ASSERT_NOW(a_no_overflow, wr_en, !full, "write into full queue")
  `ESD_ASSERT_NOW(a_no_underflow, rd_en, !q_empty, "read from empty queue")

endmodule

FILE: hw/rtl/esd_back.sv
`timescale 1ns / 1ps

module esd_back import esd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  esd_rec_t           q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [15:0] step_x,
  output logic signed [15:0] step_y,
  output logic [1:0]         stitch_kind
);

  logic        out_valid;
  logic        load;
  logic [15:0] x_next;
  logic [15:0] y_next;
  logic [1:0]  kind_next;

  // refill the output register when it is free or being taken
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load;
  assign empty = !out_valid;

  always_comb begin
    x_next    = q_data.x;
    y_next    = q_data.y;
    kind_next = KIND_NORMAL;
    if (!q_data.is_escape) begin
      x_next = {{8{q_data.x[7]}}, q_data.x[7:0]};
      y_next = {{8{q_data.y[7]}}, q_data.y[7:0]};
    end else begin
      unique case (q_data.code)
        CODE_END: begin
          x_next    = '0;
          y_next    = '0;
          kind_next = KIND_END;
        end
        CODE_STOP: kind_next = KIND_STOP;
        CODE_TRIM: kind_next = KIND_TRIM;
        default:   kind_next = KIND_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step_x      <= x_next;
      step_y      <= y_next;
      stitch_kind <= kind_next;
    end
  end

endmodule
